### design/mpbm_pkg.sv
// Shared types and constants for the multi-pattern byte matcher.
`timescale 1ns / 1ps
package mpbm_pkg;
  localparam int MAX_NODES  = 256;
  localparam int OUTPUT_IDS = 64;
  localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int TT_AW      = NODE_W + 8;
  localparam int TT_DEPTH   = MAX_NODES * 256;
  localparam int MASK_W     = OUTPUT_IDS;
  localparam int ID_W       = 6;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_BUILD  = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_DROPPED   = 2'd2
  } status_t;

  typedef struct packed {
    op_t             op;
    logic [7:0]      byte_value;
    logic [ID_W-1:0] out_id;
    logic            last;
  } cmd_t;

  // front to back: head of the command queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // back to front: dequeue and init status
  typedef struct packed {
    logic pop;
    logic init_done;
  } be_ctl_t;
endpackage

### design/multi_pattern_byte_matcher.sv
// Top level of the Aho-Corasick multi-pattern byte matcher.
`timescale 1ns / 1ps
// Usage:
//   Input: drive in_operation / in_byte_value / in_out_id / in_last and pulse
//   start; a transfer happens on a clock edge with start high and busy low.
//   Add items (op 0) build the trie one byte at a time; in_last attaches
//   id bit in_out_id to the end node. One build item (op 1) then walks the
//   trie breadth first to set fail links and merge output masks. Search
//   items (op 2) walk the text; the item with in_last high produces one
//   result. Op 3 is dropped.
//   Output: out_valid is high for one cycle with out_matched_mask and
//   out_status; the receiver cannot stall, so results are never held.
//   Queue: a four-entry command queue decouples accept from execution.
//   An add reads the transition memory and, on its last byte, updates
//   the mask; a search reads it, following fail links until a child is
//   found, then reads the mask. The build scans all 256 byte slots of
//   the root and of each queued node, following fail links per child
//   below depth one; results are registered from the last search step.
//   Reset: after rst_n the engine sweeps the MAX_NODES * 256 = 65536
//   transition memory entries to zero, one entry a cycle, busy high.
module multi_pattern_byte_matcher (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_operation,
  input  logic [7:0]                        in_byte_value,
  input  logic [mpbm_pkg::ID_W-1:0]         in_out_id,
  input  logic                              in_last,
  output logic                              out_valid,
  output logic [mpbm_pkg::MASK_W-1:0]       out_matched_mask,
  output logic [1:0]                        out_status
);
  import mpbm_pkg::*;

  q_head_t head;
  be_ctl_t be_ctl;

  // classify and queue each transfer
  mpbm_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_byte_value, .in_out_id, .in_last,
    .head, .be_ctl
  );

  // execute queued commands against the trie memories
  mpbm_back u_back (
    .clk, .rst_n, .head, .be_ctl,
    .out_valid, .out_matched_mask, .out_status
  );
endmodule

### design/mpbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/mpbm_front.sv
// Front end: decodes incoming commands and queues them for the engine.
`timescale 1ns / 1ps
module mpbm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_byte_value,
  input  logic [mpbm_pkg::ID_W-1:0] in_out_id,
  input  logic                  in_last,
  output mpbm_pkg::q_head_t     head,
  input  mpbm_pkg::be_ctl_t     be_ctl
);
  import mpbm_pkg::*;

  cmd_t           q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           acc, push, known;

  assign busy  = (cnt_r == (QAW+1)'(QDEPTH)) || !be_ctl.init_done;
  assign acc   = start && !busy;
  // drop unknown operation codes here
  assign known = (in_operation == OP_ADD) || (in_operation == OP_BUILD) ||
                 (in_operation == OP_SEARCH);
  assign push  = acc && known;

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{op: op_t'(in_operation), byte_value: in_byte_value,
                     out_id: in_out_id, last: in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (be_ctl.pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(be_ctl.pop);
    end
  end
endmodule

### design/mpbm_back.sv
// Back end: trie insert, breadth-first fail-link build and text search.
`timescale 1ns / 1ps
module mpbm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mpbm_pkg::q_head_t           head,
  output mpbm_pkg::be_ctl_t           be_ctl,
  output logic                        out_valid,
  output logic [mpbm_pkg::MASK_W-1:0] out_matched_mask,
  output logic [1:0]                  out_status
);
  import mpbm_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'd1,
    S_IDLE   = 14'd2,
    S_ADD_RD = 14'd4,
    S_ADD_MK = 14'd8,
    S_SR_CHK = 14'd16,
    S_SR_FL  = 14'd32,
    S_SR_MK  = 14'd64,
    S_BL_CH  = 14'd128,
    S_BL_FC  = 14'd256,
    S_BL_FF  = 14'd512,
    S_BL_M1  = 14'd1024,
    S_BL_M2  = 14'd2048,
    S_BL_Q   = 14'd4096,
    S_BL_QF  = 14'd8192
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic [TT_AW-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0]  ncnt_r, ncnt_nxt, qh_r, qh_nxt, qt_r, qt_nxt;
  logic [NODE_W-1:0] ins_r, ins_nxt, mcur_r, mcur_nxt, n_r, n_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt, fcur_r, fcur_nxt, f_r, f_nxt, c_r, c_nxt;
  logic [7:0]        b_r, b_nxt;
  logic              built_r, built_nxt, ovf_r, ovf_nxt, drop_r, drop_nxt;
  logic              root_r, root_nxt;
  logic [MASK_W-1:0] acc_r, acc_nxt, tmp_r, tmp_nxt;
  logic              ov_r, ov_nxt;
  logic [MASK_W-1:0] omask_r, omask_nxt;
  status_t           ost_r, ost_nxt;

  logic              tt_we, fl_we, mk_we, bq_we;
  logic [TT_AW-1:0]  tt_wa, tt_ra;
  logic [NODE_W-1:0] tt_wd, tt_rd, fl_wa, fl_ra, fl_wd, fl_rd;
  logic [NODE_W-1:0] mk_wa, mk_ra, bq_wa, bq_ra, bq_wd, bq_rd;
  logic [MASK_W-1:0] mk_wd, mk_rd;
  logic              id_ok;

  mpbm_ram #(.WIDTH(NODE_W), .DEPTH(TT_DEPTH)) u_tt (
    .clk, .we(tt_we), .waddr(tt_wa), .wdata(tt_wd), .raddr(tt_ra), .rdata(tt_rd));
  mpbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fl (
    .clk, .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
  mpbm_ram #(.WIDTH(MASK_W), .DEPTH(MAX_NODES)) u_mk (
    .clk, .we(mk_we), .waddr(mk_wa), .wdata(mk_wd), .raddr(mk_ra), .rdata(mk_rd));
  mpbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_bq (
    .clk, .we(bq_we), .waddr(bq_wa), .wdata(bq_wd), .raddr(bq_ra), .rdata(bq_rd));

  assign out_valid        = ov_r;
  assign out_matched_mask = omask_r;
  assign out_status       = ost_r;
  assign id_ok = ({1'b0, cmd_r.out_id} < (ID_W+1)'(OUTPUT_IDS));

  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; clr_nxt = clr_r;
    ncnt_nxt = ncnt_r; qh_nxt = qh_r; qt_nxt = qt_r;
    ins_nxt = ins_r; mcur_nxt = mcur_r; n_nxt = n_r;
    cur_nxt = cur_r; fcur_nxt = fcur_r; f_nxt = f_r; c_nxt = c_r; b_nxt = b_r;
    built_nxt = built_r; ovf_nxt = ovf_r; drop_nxt = drop_r; root_nxt = root_r;
    acc_nxt = acc_r; tmp_nxt = tmp_r;
    ov_nxt = 1'b0; omask_nxt = omask_r; ost_nxt = ost_r;
    tt_we = 1'b0; tt_wa = '0; tt_wd = '0; tt_ra = '0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
    mk_we = 1'b0; mk_wa = '0; mk_wd = '0; mk_ra = '0;
    bq_we = 1'b0; bq_wa = qt_r[NODE_W-1:0]; bq_wd = '0; bq_ra = qh_r[NODE_W-1:0];
    be_ctl.pop = 1'b0;
    be_ctl.init_done = (state_r != S_CLEAR);

    unique case (state_r)
      S_CLEAR: begin
        tt_we = 1'b1; tt_wa = clr_r;
        if (clr_r < TT_AW'(MAX_NODES)) begin
          fl_we = 1'b1; fl_wa = clr_r[NODE_W-1:0];
          mk_we = 1'b1; mk_wa = clr_r[NODE_W-1:0];
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TT_AW'(TT_DEPTH - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (head.valid) begin
          be_ctl.pop = 1'b1;
          cmd_nxt = head.cmd;
          unique case (head.cmd.op)
            OP_ADD: begin
              if (!built_r) begin
                if (drop_r) begin
                  if (head.cmd.last) begin
                    drop_nxt = 1'b0;
                    ins_nxt  = '0;
                  end
                end else begin
                  tt_ra = {ins_r, head.cmd.byte_value};
                  state_nxt = S_ADD_RD;
                end
              end
            end
            OP_BUILD: begin
              if (!built_r) begin
                built_nxt = 1'b1;
                cur_nxt = '0; root_nxt = 1'b1; b_nxt = '0;
                qh_nxt = '0; qt_nxt = '0;
                tt_ra = '0;
                state_nxt = S_BL_CH;
              end
            end
            OP_SEARCH: begin
              if (built_r) begin
                n_nxt = mcur_r;
                tt_ra = {mcur_r, head.cmd.byte_value};
                state_nxt = S_SR_CHK;
              end else if (head.cmd.last) begin
                ov_nxt = 1'b1; omask_nxt = '0; ost_nxt = ST_NOT_BUILT;
                acc_nxt = '0; mcur_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_ADD_RD: begin
        state_nxt = S_IDLE;
        if (tt_rd == '0 && ncnt_r >= CNT_W'(MAX_NODES)) begin
          ovf_nxt = 1'b1;
          ins_nxt = '0;
          if (!cmd_r.last) drop_nxt = 1'b1;
        end else begin
          if (tt_rd == '0) begin
            tt_we = 1'b1; tt_wa = {ins_r, cmd_r.byte_value};
            tt_wd = ncnt_r[NODE_W-1:0];
            ncnt_nxt = ncnt_r + 1'b1;
            n_nxt = ncnt_r[NODE_W-1:0];
          end else begin
            n_nxt = tt_rd;
          end
          ins_nxt = n_nxt;
          if (cmd_r.last) begin
            ins_nxt = '0;
            if (id_ok) begin
              mk_ra = n_nxt;
              state_nxt = S_ADD_MK;
            end
          end
        end
      end

      S_ADD_MK: begin
        mk_we = 1'b1; mk_wa = n_r;
        mk_wd = mk_rd | (MASK_W'(1) << cmd_r.out_id);
        state_nxt = S_IDLE;
      end

      S_SR_CHK: begin
        if (n_r != '0 && tt_rd == '0) begin
          fl_ra = n_r;
          state_nxt = S_SR_FL;
        end else begin
          mcur_nxt = tt_rd;
          mk_ra = tt_rd;
          state_nxt = S_SR_MK;
        end
      end

      S_SR_FL: begin
        n_nxt = fl_rd;
        tt_ra = {fl_rd, cmd_r.byte_value};
        state_nxt = S_SR_CHK;
      end

      S_SR_MK: begin
        acc_nxt = acc_r | mk_rd;
        state_nxt = S_IDLE;
        if (cmd_r.last) begin
          ov_nxt = 1'b1;
          omask_nxt = acc_r | mk_rd;
          ost_nxt = ovf_r ? ST_DROPPED : ST_OK;
          acc_nxt = '0; mcur_nxt = '0;
        end
      end

      S_BL_CH, S_BL_M2: begin
        logic adv;
        adv = 1'b0;
        if (state_r == S_BL_M2) begin
          mk_we = 1'b1; mk_wa = c_r; mk_wd = mk_rd | tmp_r;
          adv = 1'b1;
        end else if (tt_rd == '0) begin
          adv = 1'b1;
        end else begin
          c_nxt = tt_rd;
          if (qt_r < CNT_W'(MAX_NODES)) begin
            bq_we = 1'b1; bq_wd = tt_rd;
            qt_nxt = qt_r + 1'b1;
          end
          if (root_r) begin
            fl_we = 1'b1; fl_wa = tt_rd; fl_wd = '0;
            adv = 1'b1;
          end else begin
            f_nxt = fcur_r;
            tt_ra = {fcur_r, b_r};
            state_nxt = S_BL_FC;
          end
        end
        if (adv) begin
          if (b_r == 8'hFF) begin
            if (qh_r == qt_nxt) begin
              state_nxt = S_IDLE;
            end else begin
              qh_nxt = qh_r + 1'b1;
              state_nxt = S_BL_Q;
            end
          end else begin
            b_nxt = b_r + 1'b1;
            tt_ra = {cur_r, b_nxt};
            state_nxt = S_BL_CH;
          end
        end
      end

      S_BL_FC: begin
        if (f_r != '0 && tt_rd == '0) begin
          fl_ra = f_r;
          state_nxt = S_BL_FF;
        end else begin
          fl_we = 1'b1; fl_wa = c_r; fl_wd = tt_rd;
          mk_ra = tt_rd;
          state_nxt = S_BL_M1;
        end
      end

      S_BL_FF: begin
        f_nxt = fl_rd;
        tt_ra = {fl_rd, b_r};
        state_nxt = S_BL_FC;
      end

      S_BL_M1: begin
        tmp_nxt = mk_rd;
        mk_ra = c_r;
        state_nxt = S_BL_M2;
      end

      S_BL_Q: begin
        // last entry of the queue may have been written on the read cycle;
        // it is always the last child found, still held in c_r
        cur_nxt = (qh_r == qt_r) ? c_r : bq_rd;
        fl_ra = cur_nxt;
        state_nxt = S_BL_QF;
      end

      S_BL_QF: begin
        fcur_nxt = fl_rd;
        root_nxt = 1'b0;
        b_nxt = '0;
        tt_ra = {cur_r, 8'h00};
        state_nxt = S_BL_CH;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0;
      ncnt_r <= CNT_W'(1); ins_r <= '0; mcur_r <= '0;
      built_r <= 1'b0; ovf_r <= 1'b0; drop_r <= 1'b0;
      acc_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt;
      ncnt_r <= ncnt_nxt; ins_r <= ins_nxt; mcur_r <= mcur_nxt;
      built_r <= built_nxt; ovf_r <= ovf_nxt; drop_r <= drop_nxt;
      acc_r <= acc_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; qh_r <= qh_nxt; qt_r <= qt_nxt;
    n_r <= n_nxt; cur_r <= cur_nxt; fcur_r <= fcur_nxt;
    f_r <= f_nxt; c_r <= c_nxt; b_r <= b_nxt; root_r <= root_nxt;
    tmp_r <= tmp_nxt; omask_r <= omask_nxt; ost_r <= ost_nxt;
  end
endmodule

### verif/multi_pattern_byte_matcher_tb.sv
// Self-checking testbench for the multi-pattern byte matcher: trie build, overflow and search.
`timescale 1ns / 1ps
module multi_pattern_byte_matcher_tb;
  import mpbm_pkg::*;

  // Operation code 3 is reserved; the block must drop it without a result.
  localparam logic [1:0] OP_RESERVED = 2'd3;
  // Cycles to wait once nothing is pending, so that a late result still shows.
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    status_t           status;
  } match_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_operation = '0;
  logic [7:0]        in_byte_value = '0;
  logic [ID_W-1:0]   in_out_id = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic [MASK_W-1:0] out_matched_mask;
  logic [1:0]        out_status;

  always #2 clk = ~clk;

  multi_pattern_byte_matcher uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_byte_value    (in_byte_value),
    .in_out_id        (in_out_id),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_matched_mask (out_matched_mask),
    .out_status       (out_status)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the trie, links, masks and cursors.
  // ---------------------------------------------------------------------------
  int unsigned       trie_child [0:MAX_NODES*256-1];
  int unsigned       fail_to [0:MAX_NODES-1];
  logic [MASK_W-1:0] hit_mask [0:MAX_NODES-1];
  int unsigned       nodes_used;
  int unsigned       insert_node;
  bit                trie_built;
  bit                store_overflow;
  bit                dropping_pattern;
  int unsigned       walk_node;
  logic [MASK_W-1:0] hits_so_far;

  match_report_t     pending_reports[$];
  int                errors;
  int                transfers;
  int                reports_checked;
  int                sender_idle_pct;

  // Pick a byte from a tiny alphabet most of the time, so that patterns
  // share prefixes and texts actually hit them; sometimes any byte at all.
  byte unsigned      alphabet [0:5] = '{8'h68, 8'h65, 8'h73, 8'h72, 8'h00, 8'hff};

  function automatic byte unsigned pick_byte(int any_pct);
    if ($urandom_range(99) < any_pct) return byte'($urandom_range(255));
    return alphabet[$urandom_range(5)];
  endfunction

  function automatic int unsigned child(int unsigned node, int unsigned b);
    return trie_child[(node % MAX_NODES) * 256 + (b & 8'hff)];
  endfunction

  function automatic void insert_byte(int unsigned b, int unsigned id, bit last);
    int unsigned nxt;
    if (trie_built) return;
    if (dropping_pattern) begin
      // Discard the tail of a pattern that ran out of nodes.
      if (last) begin
        dropping_pattern = 1'b0;
        insert_node = 0;
      end
      return;
    end
    nxt = child(insert_node, b);
    if (nxt == 0) begin
      if (nodes_used >= MAX_NODES) begin
        store_overflow = 1'b1;
        insert_node = 0;
        if (!last) dropping_pattern = 1'b1;
        return;
      end
      nxt = nodes_used;
      nodes_used++;
      trie_child[insert_node * 256 + b] = nxt;
    end
    insert_node = nxt;
    if (last) begin
      if (id < OUTPUT_IDS) hit_mask[insert_node] |= MASK_W'(1) << id;
      insert_node = 0;
    end
  endfunction

  function automatic void link_trie();
    int unsigned order[$];
    int unsigned cur, c, f, guard;
    if (trie_built) return;
    trie_built = 1'b1;
    for (int b = 0; b < 256; b++) begin
      c = child(0, b);
      if (c != 0) begin
        fail_to[c] = 0;
        order.insert(order.size(), c);
      end
    end
    // Breadth first: a node's fail target is always linked before the node.
    while (order.size() > 0) begin
      cur = order.pop_front();
      for (int b = 0; b < 256; b++) begin
        c = child(cur, b);
        if (c == 0) continue;
        order.insert(order.size(), c);
        f = fail_to[cur];
        guard = 0;
        while (f != 0 && child(f, b) == 0 && guard < MAX_NODES) begin
          f = fail_to[f];
          guard++;
        end
        fail_to[c] = child(f, b);
        hit_mask[c] |= hit_mask[fail_to[c]];
      end
    end
  endfunction

  function automatic void scan_byte(int unsigned b, bit last);
    int unsigned n, guard;
    match_report_t rep;
    if (trie_built) begin
      n = walk_node;
      guard = 0;
      while (n != 0 && child(n, b) == 0 && guard < MAX_NODES) begin
        n = fail_to[n];
        guard++;
      end
      n = child(n, b);
      walk_node = n;
      hits_so_far |= hit_mask[n];
    end
    if (!last) return;
    if (trie_built) begin
      rep.mask   = hits_so_far;
      rep.status = store_overflow ? ST_DROPPED : ST_OK;
    end else begin
      rep.mask   = '0;
      rep.status = ST_NOT_BUILT;
    end
    pending_reports.insert(pending_reports.size(), rep);
    hits_so_far = '0;
    walk_node = 0;
  endfunction

  function automatic void predict_transfer(logic [1:0] op, byte unsigned b,
                                           logic [ID_W-1:0] id, bit last);
    case (op)
      OP_ADD:    insert_byte(int'(b), int'(id), last);
      OP_BUILD:  link_trie();
      OP_SEARCH: scan_byte(int'(b), last);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving: one transfer per call, with random idle cycles ahead of it.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(logic [1:0] op, byte unsigned b, logic [ID_W-1:0] id, bit last);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_byte_value <= b;
    in_out_id     <= id;
    in_last       <= last;
    @(posedge clk);
    // Hold the command until the block takes it.
    while (busy) @(posedge clk);
    transfers++;
    predict_transfer(op, b, id, last);
  endtask

  // Drop start and wait until every expected report is back, then settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pattern(int len, int any_pct);
    for (int i = 0; i < len; i++)
      send_cmd(OP_ADD, pick_byte(any_pct), ID_W'($urandom_range(OUTPUT_IDS - 1)), i == len - 1);
  endtask

  task automatic send_text(int len, int any_pct);
    for (int i = 0; i < len; i++)
      send_cmd(OP_SEARCH, pick_byte(any_pct), ID_W'($urandom), i == len - 1);
  endtask

  task automatic send_word(string s, logic [1:0] op, logic [ID_W-1:0] id);
    for (int i = 0; i < s.len(); i++)
      send_cmd(op, s[i], id, i == s.len() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Checking: the receiver cannot stall, so every strobe is one report.
  // ---------------------------------------------------------------------------
  task automatic report(string what, logic [MASK_W-1:0] expv, logic [MASK_W-1:0] gotv);
    errors++;
    $display("[%0t] MISMATCH %s: expected %h got %h", $realtime, what, expv, gotv);
  endtask

  always @(posedge clk) begin
    match_report_t want;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        report("report with none pending", '0, out_matched_mask);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_matched_mask !== want.mask) report("matched_mask", want.mask, out_matched_mask);
        if (out_status !== want.status)
          report("status", MASK_W'(want.status), MASK_W'(out_status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Searching before any build must report an empty mask and not-built status;
  // the reserved operation must vanish without a report.
  task automatic test_search_unbuilt();
    send_cmd(OP_SEARCH, 8'h00, '0, 1'b0);
    send_cmd(OP_SEARCH, 8'hff, '1, 1'b1);
    send_cmd(OP_SEARCH, 8'h68, '0, 1'b1);
    send_cmd(OP_RESERVED, 8'haa, 6'h15, 1'b1);
    send_cmd(OP_RESERVED, 8'h55, 6'h2a, 1'b0);
  endtask

  // Classic overlapping set plus extreme bytes and the top output id.
  task automatic test_directed_patterns();
    send_word("he", OP_ADD, 6'd0);
    send_word("she", OP_ADD, 6'd1);
    send_word("his", OP_ADD, 6'd2);
    send_word("hers", OP_ADD, 6'd3);
    send_cmd(OP_ADD, 8'h00, '0, 1'b0);
    send_cmd(OP_ADD, 8'hff, 6'd63, 1'b1);
  endtask

  // Many short patterns over a small alphabet so prefixes are shared.
  task automatic test_random_patterns();
    sender_idle_pct = 55;
    for (int p = 0; p < 60; p++) send_pattern($urandom_range(1, 5), 10);
  endtask

  // Fill the node store with random-byte patterns until it overflows, then
  // a few more so both drop paths (mid pattern and on the last byte) occur.
  task automatic test_overflow();
    int extra;
    sender_idle_pct = 15;
    extra = 0;
    while (extra < 6) begin
      send_pattern($urandom_range(2, 8), 90);
      if (store_overflow) extra++;
    end
    send_cmd(OP_ADD, 8'h01, 6'd9, 1'b1);
  endtask

  // One build; a second build and later adds must change nothing.
  task automatic test_build();
    sender_idle_pct = 0;
    send_cmd(OP_BUILD, byte'($urandom), ID_W'($urandom), 1'b0);
    send_cmd(OP_BUILD, byte'($urandom), ID_W'($urandom), 1'b1);
    send_word("zz", OP_ADD, 6'd40);
    drain();
  endtask

  // Texts over the same alphabet, under each idling phase, with noise mixed in.
  task automatic test_search(int idle_pct, int texts);
    sender_idle_pct = idle_pct;
    send_word("ushers", OP_SEARCH, '0);
    for (int t = 0; t < texts; t++) begin
      if ($urandom_range(9) == 0)
        send_cmd($urandom_range(1) ? OP_RESERVED : OP_ADD, byte'($urandom),
                 ID_W'($urandom), 1'($urandom));
      send_text($urandom_range(1, 10), 10);
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_NODES * 256; i++) trie_child[i] = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      fail_to[i]  = 0;
      hit_mask[i] = '0;
    end
    nodes_used = 1;
    insert_node = 0;
    trie_built = 1'b0;
    store_overflow = 1'b0;
    dropping_pattern = 1'b0;
    walk_node = 0;
    hits_so_far = '0;
    errors = 0;
    transfers = 0;
    reports_checked = 0;
    sender_idle_pct = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_search_unbuilt();
    test_directed_patterns();
    drain();
    test_random_patterns();
    test_overflow();
    test_build();
    test_search(0, 20);
    test_search(55, 20);
    test_search(15, 20);
    drain();

    $display("Covered %0d transfers and %0d match reports; trie held %0d nodes, overflow %0d.",
             transfers, reports_checked, nodes_used, store_overflow);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // The reset sweep and the build are both long; allow plenty of time.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule

### filelist.f
design/mpbm_pkg.sv
design/mpbm_ram.sv
design/mpbm_front.sv
design/mpbm_back.sv
design/multi_pattern_byte_matcher.sv
verif/multi_pattern_byte_matcher_tb.sv
